### src/frq_pkg.sv
// shared types and codes for the fcfs ready queue scheduler
// no dependencies

package frq_pkg;

    // event kinds
    typedef enum logic [1:0] {
        FUNC_NEW   = 2'd0,
        FUNC_EXIT  = 2'd1,
        FUNC_WAKE  = 2'd2,
        FUNC_SCHED = 2'd3
    } t_func;

    // result status codes
    typedef enum logic [1:0] {
        STAT_OK   = 2'd0,
        STAT_FULL = 2'd1,
        STAT_BAD  = 2'd2,
        STAT_IDLE = 2'd3
    } t_status;

    // sequencer states
    typedef enum logic [1:0] {
        S_IDLE  = 2'd0,
        S_FETCH = 2'd1,
        S_EXEC  = 2'd2
    } t_state;

endpackage

### src/frq_evt_if.sv
// event channel: valid/ready handshake carrying one scheduler event item
// depends on frq_pkg

interface frq_evt_if import frq_pkg::*; ();
    logic       valid;
    logic       ready;
    t_func      func;
    logic [1:0] cpu_index;
    logic [7:0] task_id;
    logic       runnable;
    logic       running;

    modport source (output valid, func, cpu_index, task_id, runnable, running,
                    input ready);
    modport sink   (input valid, func, cpu_index, task_id, runnable, running,
                    output ready);
endinterface

### src/frq_res_if.sv
// result channel: valid/ready handshake carrying one scheduler result item
// depends on frq_pkg

interface frq_res_if import frq_pkg::*; ();
    logic       valid;
    logic       ready;
    logic       next_valid;
    logic [7:0] next_task;
    t_status    status;
    logic [4:0] queue_length;

    modport source (output valid, next_valid, next_task, status, queue_length,
                    input ready);
    modport sink   (input valid, next_valid, next_task, status, queue_length,
                    output ready);
endinterface

### src/frq_ctrl_mem.sv
// per-processor control word memory, one read and one write port
// entries read as zero until first written (valid bit per entry)

module frq_ctrl_mem #(
    parameter int DEPTH = 4,
    parameter int AW    = 2,
    parameter int DW    = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [DW-1:0] i_wr_data,
    output logic [DW-1:0] o_rd_data
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0] r_vld;
    logic [DW-1:0] r_rd_data;
    logic          r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_vld[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_vld <= r_vld[i_rd_addr];
            end
        end
    end

    // never-written entries stand at their reset value of zero
    assign o_rd_data = r_rd_vld ? r_rd_data : '0;

endmodule

### src/frq_task_mem.sv
// task id store for all ready queues, one read and one write port
// registered read data, contents undefined until written

module frq_task_mem #(
    parameter int DEPTH = 64,
    parameter int AW    = 6,
    parameter int DW    = 8
) (
    input  logic          i_clk,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [DW-1:0] i_wr_data,
    output logic [DW-1:0] o_rd_data
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### src/fcfs_ready_queue_scheduler.sv
// top level of the fcfs ready queue scheduler: sequencer, event evaluation, result register
// depends on frq_pkg, frq_evt_if, frq_res_if, frq_ctrl_mem, frq_task_mem
//
//  channel  | dir | handshake             | item
//  ---------+-----+-----------------------+----------------------------------------------
//  i_evt    | in  | valid & ready at edge | func, cpu_index, task_id, runnable, running
//  o_res    | out | valid & ready at edge | next_valid, next_task, status, queue_length
//
//  one item at a time, in steps: accept (control word read), task fetch at the queue head,
//  then evaluate and write back; the two chained synchronous reads set this order
//  reset clears the sequencer, the result valid flag and the control word valid bits;
//  no clearing pass is needed, the block takes an item in the cycle after reset
//  a result waits in the output register; the write-back stage holds while it is full

module fcfs_ready_queue_scheduler import frq_pkg::*; #(
    parameter int NUM_CPUS     = 4,
    parameter int QUEUE_DEPTH  = 16,
    parameter int TASK_ID_BITS = 8
) (
    input  logic i_clk,
    input  logic i_rst_n,
    frq_evt_if.sink   i_evt,
    frq_res_if.source o_res
);

    localparam int CPU_AW = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
    localparam int PW     = $clog2(QUEUE_DEPTH);
    localparam int CW     = $clog2(QUEUE_DEPTH + 1);
    localparam int TW     = TASK_ID_BITS;
    localparam int CTRL_W = 2 * PW + CW + TW + 1;
    localparam int SLOTS  = NUM_CPUS * QUEUE_DEPTH;
    localparam int SAW    = $clog2(SLOTS);

    // sequencer
    t_state r_state, n_state;
    logic   w_acc;
    logic   w_ctrl_rd_en;
    logic   w_task_rd_en;
    logic   w_commit;

    // latched event
    t_func           r_func;
    logic [CPU_AW-1:0] r_cpu_a;
    logic            r_cpu_ok;
    logic [TW-1:0]   r_task;
    logic            r_runq;
    logic            r_run;
    logic            w_in_ok;

    // control word fields of the addressed processor
    logic [CTRL_W-1:0] w_ctrl_rd;
    logic [PW-1:0]     w_head;
    logic [PW-1:0]     w_tail;
    logic [CW-1:0]     w_cnt;
    logic [TW-1:0]     w_cur_t;
    logic              w_cur_v;

    // store access
    logic [SAW-1:0] w_task_rd_addr;
    logic [SAW-1:0] w_task_wr_addr;
    logic [TW-1:0]  w_task_rd;

    // evaluation results
    logic [PW-1:0]     n_head;
    logic [PW-1:0]     n_tail;
    logic [CW-1:0]     n_cnt;
    logic [TW-1:0]     n_cur_t;
    logic              n_cur_v;
    logic              w_push;
    logic [TW-1:0]     w_push_task;
    logic              w_nvalid;
    logic [TW-1:0]     w_ntask;
    t_status           w_status;

    // result register
    logic       r_out_valid;
    logic       r_nvalid;
    logic [7:0] r_ntask;
    t_status    r_status;
    logic [4:0] r_qlen;

    function automatic logic [PW-1:0] next_slot(input logic [PW-1:0] p);
        next_slot = (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign w_acc   = i_evt.valid && i_evt.ready;
    assign w_in_ok = 32'(i_evt.cpu_index) < NUM_CPUS;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (w_acc) n_state = S_FETCH;
            S_FETCH: n_state = S_EXEC;
            S_EXEC:  if (!r_out_valid || o_res.ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        i_evt.ready  = 1'b0;
        w_ctrl_rd_en = 1'b0;
        w_task_rd_en = 1'b0;
        w_commit     = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                i_evt.ready  = 1'b1;
                w_ctrl_rd_en = i_evt.valid && w_in_ok;
            end
            S_FETCH: begin
                w_task_rd_en = r_cpu_ok;
            end
            S_EXEC: begin
                w_commit = !r_out_valid || o_res.ready;
            end
            default: begin
                i_evt.ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_func   <= i_evt.func;
            r_cpu_a  <= CPU_AW'(i_evt.cpu_index);
            r_cpu_ok <= w_in_ok;
            r_task   <= TW'(i_evt.task_id);
            r_runq   <= i_evt.runnable;
            r_run    <= i_evt.running;
        end
    end

    // control words: head, tail, count, running task, running flag
    frq_ctrl_mem #(
        .DEPTH (NUM_CPUS),
        .AW    (CPU_AW),
        .DW    (CTRL_W)
    ) u_ctrl_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (w_ctrl_rd_en),
        .i_rd_addr (CPU_AW'(i_evt.cpu_index)),
        .i_wr_en   (w_commit && r_cpu_ok),
        .i_wr_addr (r_cpu_a),
        .i_wr_data ({n_head, n_tail, n_cnt, n_cur_t, n_cur_v}),
        .o_rd_data (w_ctrl_rd)
    );

    assign {w_head, w_tail, w_cnt, w_cur_t, w_cur_v} = w_ctrl_rd;

    // queue slots of processor c start at c * QUEUE_DEPTH
    assign w_task_rd_addr = SAW'(r_cpu_a) * SAW'(QUEUE_DEPTH) + SAW'(w_head);
    assign w_task_wr_addr = SAW'(r_cpu_a) * SAW'(QUEUE_DEPTH) + SAW'(w_tail);

    frq_task_mem #(
        .DEPTH (SLOTS),
        .AW    (SAW),
        .DW    (TW)
    ) u_task_mem (
        .i_clk     (i_clk),
        .i_rd_en   (w_task_rd_en),
        .i_rd_addr (w_task_rd_addr),
        .i_wr_en   (w_commit && r_cpu_ok && w_push),
        .i_wr_addr (w_task_wr_addr),
        .i_wr_data (w_push_task),
        .o_rd_data (w_task_rd)
    );

    // event evaluation on the fetched control word and queue head
    always_comb begin
        logic is_cur;
        logic has_room;
        logic non_empty;
        is_cur    = w_cur_v && (w_cur_t == r_task);
        has_room  = w_cnt != CW'(QUEUE_DEPTH);
        non_empty = w_cnt != '0;

        n_head      = w_head;
        n_tail      = w_tail;
        n_cnt       = w_cnt;
        n_cur_t     = w_cur_t;
        n_cur_v     = w_cur_v;
        w_push      = 1'b0;
        w_push_task = r_task;
        w_nvalid    = 1'b0;
        w_ntask     = '0;
        w_status    = STAT_OK;

        if (!r_cpu_ok) begin
            w_status = STAT_BAD;
        end else begin
            case (r_func)
                FUNC_NEW: begin
                    if (r_run) begin
                        if (w_cur_v) begin
                            w_status = STAT_BAD;
                        end else begin
                            n_cur_t = r_task;
                            n_cur_v = 1'b1;
                        end
                    end else if (r_runq) begin
                        if (has_room) begin
                            w_push = 1'b1;
                        end else begin
                            w_status = STAT_FULL;
                        end
                    end
                end
                FUNC_EXIT: begin
                    if (is_cur) begin
                        n_cur_v = 1'b0;
                    end
                end
                FUNC_WAKE: begin
                    if (!is_cur) begin
                        if (has_room) begin
                            w_push = 1'b1;
                        end else begin
                            w_status = STAT_FULL;
                        end
                    end
                end
                default: begin
                    if (w_cur_v && !is_cur) begin
                        w_status = STAT_BAD;
                    end else if (w_cur_v) begin
                        // preempt: rotate the running task and the head, count unchanged
                        w_nvalid = 1'b1;
                        w_ntask  = w_cur_t;
                        if (non_empty) begin
                            w_push      = 1'b1;
                            w_push_task = w_cur_t;
                            n_head      = next_slot(w_head);
                            n_cur_t     = w_task_rd;
                            w_ntask     = w_task_rd;
                        end
                    end else if (non_empty) begin
                        n_head   = next_slot(w_head);
                        n_cnt    = w_cnt - 1'b1;
                        n_cur_t  = w_task_rd;
                        n_cur_v  = 1'b1;
                        w_nvalid = 1'b1;
                        w_ntask  = w_task_rd;
                    end else begin
                        w_status = STAT_IDLE;
                    end
                end
            endcase

            // a push on its own grows the queue; with a pop it is a rotation
            if (w_push) begin
                n_tail = next_slot(w_tail);
                if (r_func != FUNC_SCHED) begin
                    n_cnt = w_cnt + 1'b1;
                end
            end
        end
    end

    // result register: loaded at write-back, freed when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_commit) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_commit) begin
            r_nvalid <= w_nvalid;
            r_ntask  <= 8'(w_ntask);
            r_status <= w_status;
            r_qlen   <= r_cpu_ok ? 5'(n_cnt) : 5'd0;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.next_valid   = r_nvalid;
    assign o_res.next_task    = r_ntask;
    assign o_res.status       = r_status;
    assign o_res.queue_length = r_qlen;

endmodule

### tb/frq_queue_checker.sv
`timescale 1ns / 100ps
// checker for fcfs_ready_queue_scheduler: keeps its own per-processor queues and running slots,
// predicts one result item per accepted event item and compares results in order
// depends on frq_pkg, frq_evt_if, frq_res_if

module frq_queue_checker import frq_pkg::*; #(
    parameter int NUM_CPUS     = 4,
    parameter int QUEUE_DEPTH  = 16,
    parameter int TASK_ID_BITS = 8
) (
    input  logic i_clk,
    input  logic i_rst_n,
    frq_evt_if   i_evt,
    frq_res_if   i_res,
    output int   o_fail_count,
    output int   o_pending
);

    localparam logic [7:0] TASK_MASK = 8'((1 << TASK_ID_BITS) - 1);
    localparam int MAX_SHOWN = 10;

    typedef struct packed {
        logic       next_valid;
        logic [7:0] next_task;
        t_status    status;
        logic [4:0] queue_length;
    } t_sched_res;

    logic [7:0]  slot_mem [NUM_CPUS][QUEUE_DEPTH];
    int unsigned rd_ptr [NUM_CPUS];
    int unsigned wr_ptr [NUM_CPUS];
    int unsigned fill [NUM_CPUS];
    logic [7:0]  cur_task [NUM_CPUS];
    logic        cur_busy [NUM_CPUS];
    t_sched_res  pending_results [$];
    int          shown;

    function automatic bit queue_push(int c, logic [7:0] tid);
        if (fill[c] >= QUEUE_DEPTH) return 1'b0;
        slot_mem[c][wr_ptr[c]] = tid;
        wr_ptr[c] = (wr_ptr[c] + 1) % QUEUE_DEPTH;
        fill[c]++;
        return 1'b1;
    endfunction

    function automatic logic [7:0] queue_pop(int c);
        logic [7:0] tid;
        tid = slot_mem[c][rd_ptr[c]];
        rd_ptr[c] = (rd_ptr[c] + 1) % QUEUE_DEPTH;
        fill[c]--;
        return tid;
    endfunction

    // applies one event to the tracked state and returns the result item it gives
    function automatic t_sched_res apply_event(t_func f, logic [1:0] cpu, logic [7:0] tid_in,
                                               logic runnable, logic running);
        t_sched_res r;
        logic [7:0] tid;
        logic [7:0] nxt;
        logic       hit;
        int         c;
        r = '{next_valid: 1'b0, next_task: 8'd0, status: STAT_OK, queue_length: 5'd0};
        tid = tid_in & TASK_MASK;
        c = int'(cpu);
        if (c >= NUM_CPUS) begin
            // unknown processor: nothing changes
            r.status = STAT_BAD;
        end else begin
            hit = cur_busy[c] && cur_task[c] == tid;
            case (f)
                FUNC_NEW: begin
                    if (running) begin
                        if (cur_busy[c]) begin
                            r.status = STAT_BAD;
                        end else begin
                            cur_task[c] = tid;
                            cur_busy[c] = 1'b1;
                        end
                    end else if (runnable) begin
                        if (!queue_push(c, tid)) r.status = STAT_FULL;
                    end
                end
                FUNC_EXIT: begin
                    if (hit) cur_busy[c] = 1'b0;
                end
                FUNC_WAKE: begin
                    if (!hit) begin
                        if (!queue_push(c, tid)) r.status = STAT_FULL;
                    end
                end
                default: begin
                    if (cur_busy[c] && !hit) begin
                        r.status = STAT_BAD;
                    end else if (cur_busy[c] || fill[c] != 0) begin
                        // pop first, so a full queue rotates without a drop
                        nxt = cur_task[c];
                        if (fill[c] != 0) begin
                            nxt = queue_pop(c);
                            if (cur_busy[c]) void'(queue_push(c, cur_task[c]));
                        end
                        cur_task[c] = nxt;
                        cur_busy[c] = 1'b1;
                        r.next_valid = 1'b1;
                        r.next_task = nxt;
                    end else begin
                        r.status = STAT_IDLE;
                    end
                end
            endcase
            r.queue_length = 5'(fill[c]);
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_sched_res want;
        if (!i_rst_n) begin
            for (int c = 0; c < NUM_CPUS; c++) begin
                rd_ptr[c] = 0;
                wr_ptr[c] = 0;
                fill[c] = 0;
                cur_task[c] = 8'd0;
                cur_busy[c] = 1'b0;
            end
            pending_results.delete();
            o_fail_count = 0;
            shown = 0;
        end else begin
            // results first: one accepted in the same cycle belongs to an earlier event
            if (i_res.valid && i_res.ready) begin
                if (pending_results.size() == 0) begin
                    o_fail_count++;
                    if (shown < MAX_SHOWN) begin
                        shown++;
                        $display("unexpected result item: nv=%0b task=%02h st=%0d len=%0d",
                                 i_res.next_valid, i_res.next_task, i_res.status,
                                 i_res.queue_length);
                    end
                end else begin
                    want = pending_results.pop_front();
                    if (i_res.next_valid !== want.next_valid ||
                        i_res.next_task !== want.next_task ||
                        i_res.status !== want.status ||
                        i_res.queue_length !== want.queue_length) begin
                        o_fail_count++;
                        if (shown < MAX_SHOWN) begin
                            shown++;
                            $display("result mismatch: exp nv=%0b task=%02h st=%0d len=%0d",
                                     want.next_valid, want.next_task, want.status,
                                     want.queue_length);
                            $display("                 got nv=%0b task=%02h st=%0d len=%0d",
                                     i_res.next_valid, i_res.next_task, i_res.status,
                                     i_res.queue_length);
                        end
                    end
                end
            end
            if (i_evt.valid && i_evt.ready) begin
                pending_results.push_back(apply_event(i_evt.func, i_evt.cpu_index,
                                                      i_evt.task_id, i_evt.runnable,
                                                      i_evt.running));
            end
        end
        o_pending = pending_results.size();
    end

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps
// testbench top for fcfs_ready_queue_scheduler: clock, reset, event stimulus, result
// back-pressure and verdict; depends on frq_pkg, frq_evt_if, frq_res_if, frq_queue_checker

module tb_top import frq_pkg::*; ();

    localparam int NUM_CPUS     = 4;
    localparam int QUEUE_DEPTH  = 16;
    localparam int TASK_ID_BITS = 8;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 16;
    localparam int HOLD_CYCLES  = 400;
    localparam int SEGMENTS     = 15;
    localparam int SEG_ITEMS    = 50;
    localparam int HOLD_SEG     = 6;

    // event mixes of the random segments
    localparam int MIX_FILL  = 0;
    localparam int MIX_DRAIN = 1;
    localparam int MIX_EVEN  = 2;

    logic i_clk;
    logic i_rst_n;
    logic no_idle;
    logic pressure_go;
    logic rx_hold;
    int   rx_left;
    int   fail_count;
    int   pending;
    int   cycles;

    // rough view of each processor, only used to aim events at the running task
    logic [7:0] sh_cur [NUM_CPUS];
    logic       sh_busy [NUM_CPUS];
    logic [7:0] sh_q [NUM_CPUS][$];

    frq_evt_if evt_ch ();
    frq_res_if res_ch ();

    fcfs_ready_queue_scheduler #(
        .NUM_CPUS     (NUM_CPUS),
        .QUEUE_DEPTH  (QUEUE_DEPTH),
        .TASK_ID_BITS (TASK_ID_BITS)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_evt   (evt_ch),
        .o_res   (res_ch)
    );

    frq_queue_checker #(
        .NUM_CPUS     (NUM_CPUS),
        .QUEUE_DEPTH  (QUEUE_DEPTH),
        .TASK_ID_BITS (TASK_ID_BITS)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_evt        (evt_ch),
        .i_res        (res_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // offers one event item after a random gap, or none while no_idle is set, waits for its handshake,
    // then updates the rough view
    task automatic send_event(t_func f, logic [1:0] c, logic [7:0] tid, logic rq, logic run);
        int         gap;
        logic       hit;
        logic [7:0] nxt;
        gap = no_idle ? 0 : $urandom_range(0, 7);
        if (gap != 0) begin
            evt_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        evt_ch.valid     <= 1'b1;
        evt_ch.func      <= f;
        evt_ch.cpu_index <= c;
        evt_ch.task_id   <= tid;
        evt_ch.runnable  <= rq;
        evt_ch.running   <= run;
        @(posedge i_clk);
        while (!evt_ch.ready) @(posedge i_clk);
        hit = sh_busy[c] && sh_cur[c] == tid;
        case (f)
            FUNC_NEW: begin
                if (run) begin
                    if (!sh_busy[c]) begin
                        sh_cur[c] = tid;
                        sh_busy[c] = 1'b1;
                    end
                end else if (rq && sh_q[c].size() < QUEUE_DEPTH) begin
                    sh_q[c].push_back(tid);
                end
            end
            FUNC_EXIT: begin
                if (hit) sh_busy[c] = 1'b0;
            end
            FUNC_WAKE: begin
                if (!hit && sh_q[c].size() < QUEUE_DEPTH) sh_q[c].push_back(tid);
            end
            default: begin
                if ((hit || !sh_busy[c]) && sh_q[c].size() != 0) begin
                    nxt = sh_q[c].pop_front();
                    if (sh_busy[c]) sh_q[c].push_back(sh_cur[c]);
                    sh_cur[c] = nxt;
                    sh_busy[c] = 1'b1;
                end
            end
        endcase
    endtask

    // receiver: random wait per item unless no_idle is set, off entirely while held
    initial begin
        res_ch.ready = 1'b0;
        rx_left = 0;
        forever begin
            @(posedge i_clk);
            if (!i_rst_n || rx_hold) begin
                res_ch.ready <= 1'b0;
            end else if (res_ch.ready && res_ch.valid) begin
                rx_left = no_idle ? 0 : $urandom_range(0, 7);
                res_ch.ready <= (rx_left == 0);
            end else if (!res_ch.ready) begin
                if (rx_left > 1) rx_left--;
                else res_ch.ready <= 1'b1;
            end
        end
    end

    // long receiver stall so the block fills up and pushes back on the sender
    initial begin
        rx_hold = 1'b0;
        wait (pressure_go === 1'b1);
        @(posedge i_clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        rx_hold <= 1'b0;
    end

    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("tb_top NOT OK");
        $finish;
    end

    initial begin
        t_func      f;
        logic [1:0] c;
        logic [7:0] tid;
        logic       rq;
        logic       run;
        int         mix;
        int         focus;
        int         pick;
        int         seg;

        i_rst_n = 1'b0;
        no_idle = 1'b0;
        pressure_go = 1'b0;
        evt_ch.valid = 1'b0;
        evt_ch.func = FUNC_NEW;
        evt_ch.cpu_index = 2'd0;
        evt_ch.task_id = 8'd0;
        evt_ch.runnable = 1'b0;
        evt_ch.running = 1'b0;
        for (int i = 0; i < NUM_CPUS; i++) begin
            sh_cur[i] = 8'd0;
            sh_busy[i] = 1'b0;
        end
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: processor 0 walks through the slot and queue rules
        send_event(FUNC_SCHED, 2'd0, 8'h00, 1'b0, 1'b0);  // idle, nothing anywhere
        send_event(FUNC_NEW,   2'd0, 8'hFF, 1'b1, 1'b1);  // running wins over runnable
        send_event(FUNC_NEW,   2'd0, 8'h12, 1'b0, 1'b1);  // new running while busy
        send_event(FUNC_NEW,   2'd0, 8'h34, 1'b0, 1'b0);  // neither running nor runnable
        send_event(FUNC_SCHED, 2'd0, 8'hFF, 1'b1, 1'b1);  // empty queue, same task again
        send_event(FUNC_NEW,   2'd0, 8'h00, 1'b1, 1'b0);
        send_event(FUNC_WAKE,  2'd0, 8'hFF, 1'b0, 1'b0);  // wake of the running task
        send_event(FUNC_WAKE,  2'd0, 8'hA5, 1'b1, 1'b1);
        send_event(FUNC_SCHED, 2'd0, 8'h11, 1'b0, 1'b0);  // wrong previous task
        send_event(FUNC_SCHED, 2'd0, 8'hFF, 1'b0, 1'b0);  // preempt, pop head
        send_event(FUNC_EXIT,  2'd0, 8'h77, 1'b0, 1'b0);  // exit of a task not running
        send_event(FUNC_EXIT,  2'd0, 8'h00, 1'b1, 1'b1);
        send_event(FUNC_SCHED, 2'd0, 8'h5A, 1'b0, 1'b0);  // no running task, pop head
        // processor 3 filled to the brim, then appends dropped, a running task set and a rotate
        for (int i = 0; i < QUEUE_DEPTH; i++)
            send_event(FUNC_WAKE, 2'd3, 8'(i * 17), 1'($urandom), 1'($urandom));
        send_event(FUNC_WAKE,  2'd3, 8'hC3, 1'b0, 1'b0);
        send_event(FUNC_NEW,   2'd3, 8'h3C, 1'b1, 1'b0);
        send_event(FUNC_NEW,   2'd3, 8'h81, 1'b0, 1'b1);
        send_event(FUNC_SCHED, 2'd3, 8'h81, 1'b0, 1'b0);

        // random segments, each with its own event mix and, but for the even mix, a favoured processor
        for (seg = 0; seg < SEGMENTS; seg++) begin
            mix = (seg == HOLD_SEG) ? MIX_FILL : $urandom_range(MIX_FILL, MIX_EVEN);
            focus = $urandom_range(0, NUM_CPUS - 1);
            no_idle <= (seg == HOLD_SEG) || ($urandom_range(0, 3) == 0);
            pressure_go <= (seg == HOLD_SEG);
            repeat (SEG_ITEMS) begin
                if (mix != MIX_EVEN && $urandom_range(0, 1) != 0) c = 2'(focus);
                else c = 2'($urandom_range(0, NUM_CPUS - 1));
                tid = 8'($urandom);
                rq = 1'($urandom);
                run = 1'($urandom);
                pick = $urandom_range(0, 99);
                if ($urandom_range(0, 19) == 0) begin
                    // noise: anything at all
                    f = t_func'($urandom_range(0, 3));
                end else begin
                    if (mix == MIX_FILL)
                        f = pick < 45 ? FUNC_WAKE : pick < 75 ? FUNC_NEW :
                            pick < 90 ? FUNC_SCHED : FUNC_EXIT;
                    else if (mix == MIX_DRAIN)
                        f = pick < 50 ? FUNC_SCHED : pick < 70 ? FUNC_EXIT :
                            pick < 85 ? FUNC_WAKE : FUNC_NEW;
                    else
                        f = pick < 25 ? FUNC_NEW : pick < 50 ? FUNC_EXIT :
                            pick < 75 ? FUNC_WAKE : FUNC_SCHED;
                    case (f)
                        FUNC_NEW: begin
                            run = ($urandom_range(0, 4) == 0);
                            rq = run ? 1'($urandom) : ($urandom_range(0, 9) != 0);
                        end
                        FUNC_EXIT: begin
                            if (sh_busy[c] && $urandom_range(0, 9) < 7) tid = sh_cur[c];
                        end
                        FUNC_WAKE: begin
                            if (sh_busy[c] && $urandom_range(0, 9) == 0) tid = sh_cur[c];
                        end
                        default: begin
                            // mostly well-formed: name the task that is running
                            if (sh_busy[c] && $urandom_range(0, 19) != 0) tid = sh_cur[c];
                        end
                    endcase
                end
                send_event(f, c, tid, rq, run);
            end
        end
        evt_ch.valid <= 1'b0;

        do @(posedge i_clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule
